// ===== hw/rtl/ghs_pkg.sv =====
package ghs_pkg;

    localparam int unsigned LEN_W = 24;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] ID1_BYTE = 8'h1f;
    localparam logic [7:0] ID2_BYTE = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;

    localparam logic [7:0] FLAG_RESERVED = 8'he0;
    localparam logic [7:0] FLAG_COMMENT  = 8'h10;
    localparam logic [7:0] FLAG_NAME     = 8'h08;
    localparam logic [7:0] FLAG_EXTRA    = 8'h04;
    localparam logic [7:0] FLAG_HCRC     = 8'h02;

    localparam logic [3:0] FIXED_LAST = 4'd9;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_BAD     = 3'd2,
        KIND_TRUNC   = 3'd3,
        KIND_DROP    = 3'd4
    } t_kind;

endpackage

// ===== hw/rtl/ghs_in_if.sv =====
interface ghs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;
    logic       final_byte;

    modport source (output valid, output data_byte, output stream_start,
                    output final_byte, input ready);
    modport sink   (input valid, input data_byte, input stream_start,
                    input final_byte, output ready);
endinterface

// ===== hw/rtl/ghs_out_if.sv =====
interface ghs_out_if;
    logic                         valid;
    logic                         ready;
    ghs_pkg::t_kind               kind;
    logic [7:0]                   payload_byte;
    logic [ghs_pkg::LEN_W-1:0]    header_length;
    logic                         end_of_stream;

    modport source (output valid, output kind, output payload_byte,
                    output header_length, output end_of_stream, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input header_length, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/gzip_header_skipper_core.sv =====
// channel  dir  payload                                          accepted when
// i_in     in   data_byte[7:0] stream_start final_byte           valid && ready
// o_out    out  kind[2:0] payload_byte[7:0] header_length[23:0]  valid && ready
//               end_of_stream
//
// One item per cycle unless o_out stalls; each byte is parsed in the cycle it
// is accepted and its result lands in the output register on the same edge.
// i_in.ready is high while the output register is empty or being drained,
// so a stall on o_out stops intake after one held result.
// i_rst_n (synchronous, active low) clears the parser and the output valid.
module gzip_header_skipper_core #(
    parameter int unsigned HEADER_COUNT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ghs_in_if.sink      i_in,
    ghs_out_if.source   o_out
);

    localparam int unsigned CW = HEADER_COUNT_BITS;
    localparam int unsigned WW = (CW > ghs_pkg::LEN_W) ? CW : ghs_pkg::LEN_W;

    localparam logic [1:0] STG_EXTRA   = 2'd0;
    localparam logic [1:0] STG_NAME    = 2'd1;
    localparam logic [1:0] STG_COMMENT = 2'd2;
    localparam logic [1:0] STG_HCRC    = 2'd3;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_XDATA   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    t_phase          r_phase, n_phase, e_phase;
    logic [3:0]      r_pos, n_pos, e_pos;
    logic [7:0]      r_flags, n_flags, e_flags;
    logic [15:0]     r_xrem, n_xrem, e_xrem;
    logic [CW-1:0]   r_count, n_count, e_count;
    logic            r_failed, n_failed, e_failed;

    logic                       r_out_valid;
    ghs_pkg::t_kind             r_kind, n_kind;
    logic [7:0]                 r_pay, n_pay;
    logic [ghs_pkg::LEN_W-1:0]  r_len, n_len;
    logic                       r_eos;

    logic            in_fire;
    logic            bad;
    logic [7:0]      b;
    logic [15:0]     xlen;
    logic [15:0]     xdec;
    logic [WW-1:0]   count_ext;

    function automatic t_phase f_enter(input logic [1:0] stage, input logic [7:0] flags);
        t_phase ph;
        ph = PH_PAYLOAD;
        if (stage <= STG_HCRC && (flags & ghs_pkg::FLAG_HCRC) != 8'd0)
            ph = PH_HCRC;
        if (stage <= STG_COMMENT && (flags & ghs_pkg::FLAG_COMMENT) != 8'd0)
            ph = PH_COMMENT;
        if (stage <= STG_NAME && (flags & ghs_pkg::FLAG_NAME) != 8'd0)
            ph = PH_NAME;
        if (stage == STG_EXTRA && (flags & ghs_pkg::FLAG_EXTRA) != 8'd0)
            ph = PH_XLEN;
        return ph;
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign xlen       = {b, e_xrem[7:0]};
    assign xdec       = e_xrem - 16'd1;

    always_comb begin
        if (i_in.stream_start) begin
            e_phase  = PH_FIXED;
            e_pos    = 4'd0;
            e_flags  = 8'd0;
            e_xrem   = 16'd0;
            e_count  = '0;
            e_failed = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_pos    = r_pos;
            e_flags  = r_flags;
            e_xrem   = r_xrem;
            e_count  = r_count;
            e_failed = r_failed;
        end
    end

    always_comb begin
        n_phase  = e_phase;
        n_pos    = e_pos;
        n_flags  = e_flags;
        n_xrem   = e_xrem;
        n_count  = e_count;
        n_failed = e_failed;
        n_kind   = ghs_pkg::KIND_HEADER;
        n_pay    = 8'd0;
        bad      = 1'b0;
        if (e_failed) begin
            n_kind = ghs_pkg::KIND_DROP;
        end else if (e_phase == PH_PAYLOAD) begin
            n_kind = ghs_pkg::KIND_PAYLOAD;
            n_pay  = b;
        end else begin
            if (e_count != {CW{1'b1}}) begin
                n_count = e_count + CW'(1);
            end
            unique case (e_phase)
                PH_FIXED: begin
                    if (e_pos == 4'd0 && b != ghs_pkg::ID1_BYTE) bad = 1'b1;
                    if (e_pos == 4'd1 && b != ghs_pkg::ID2_BYTE) bad = 1'b1;
                    if (e_pos == 4'd2 && b != ghs_pkg::METHOD_DEFLATE) bad = 1'b1;
                    if (e_pos == 4'd3) begin
                        n_flags = b;
                        if ((b & ghs_pkg::FLAG_RESERVED) != 8'd0) bad = 1'b1;
                    end
                    n_pos = e_pos + 4'd1;
                    if (!bad && e_pos >= ghs_pkg::FIXED_LAST) begin
                        n_pos   = 4'd0;
                        n_phase = f_enter(STG_EXTRA, n_flags);
                    end
                end
                PH_XLEN: begin
                    if (e_pos == 4'd0) begin
                        n_xrem = {8'd0, b};
                        n_pos  = 4'd1;
                    end else begin
                        n_xrem = xlen;
                        n_pos  = 4'd0;
                        if (xlen == 16'd0) n_phase = f_enter(STG_NAME, e_flags);
                        else               n_phase = PH_XDATA;
                    end
                end
                PH_XDATA: begin
                    n_xrem = xdec;
                    if (xdec == 16'd0) begin
                        n_pos   = 4'd0;
                        n_phase = f_enter(STG_NAME, e_flags);
                    end
                end
                PH_NAME: begin
                    if (b == 8'd0) begin
                        n_pos   = 4'd0;
                        n_phase = f_enter(STG_COMMENT, e_flags);
                    end
                end
                PH_COMMENT: begin
                    if (b == 8'd0) begin
                        n_pos   = 4'd0;
                        n_phase = f_enter(STG_HCRC, e_flags);
                    end
                end
                PH_HCRC: begin
                    if (e_pos == 4'd0) begin
                        n_pos = 4'd1;
                    end else begin
                        n_pos   = 4'd0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                default: begin
                end
            endcase
            if (bad) begin
                n_kind   = ghs_pkg::KIND_BAD;
                n_failed = 1'b1;
            end else if (i_in.final_byte) begin
                n_kind   = ghs_pkg::KIND_TRUNC;
                n_failed = 1'b1;
            end
        end
    end

    assign count_ext = WW'(n_count);
    assign n_len = (count_ext > WW'(ghs_pkg::LEN_MAX)) ? ghs_pkg::LEN_MAX
                                                       : count_ext[ghs_pkg::LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIXED;
            r_pos       <= 4'd0;
            r_flags     <= 8'd0;
            r_xrem      <= 16'd0;
            r_count     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_flags  <= n_flags;
                r_xrem   <= n_xrem;
                r_count  <= n_count;
                r_failed <= n_failed;
                r_kind   <= n_kind;
                r_pay    <= n_pay;
                r_len    <= n_len;
                r_eos    <= i_in.final_byte;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.payload_byte  = r_pay;
    assign o_out.header_length = r_len;
    assign o_out.end_of_stream = r_eos;

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted item did not reach the output register");

    a_drop_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_in.stream_start && r_failed |=> r_kind == ghs_pkg::KIND_DROP)
        else $error("byte after an error was not dropped");

    a_payload_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_in.stream_start && !r_failed && r_phase == PH_PAYLOAD
        |=> r_kind == ghs_pkg::KIND_PAYLOAD && r_pay == $past(i_in.data_byte))
        else $error("payload byte not passed through");

    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != ghs_pkg::KIND_PAYLOAD |-> r_pay == 8'd0)
        else $error("payload byte set on a non-payload result");

endmodule

// ===== test/gzip_header_skipper_core_tb.sv =====
`timescale 1ns / 1ps

module gzip_header_skipper_core_tb;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_BYTES = 1450;

    typedef enum logic [2:0] {
        HDR_FIXED,
        HDR_XLEN,
        HDR_XDATA,
        HDR_NAME,
        HDR_COMMENT,
        HDR_HCRC,
        BODY
    } t_hdr_part;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } t_gz_byte;

    typedef struct packed {
        ghs_pkg::t_kind            kind;
        logic [7:0]                payload;
        logic [ghs_pkg::LEN_W-1:0] hlen;
        logic                      eos;
    } t_gz_result;

    logic i_clk;
    logic i_rst_n;

    ghs_in_if  in_ch ();
    ghs_out_if out_ch ();

    gzip_header_skipper_core #(.HEADER_COUNT_BITS(ghs_pkg::LEN_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // parser shadow state
    t_hdr_part                 part;
    logic [3:0]                pos;
    logic [7:0]                flags;
    logic [15:0]               xrem;
    logic [ghs_pkg::LEN_W-1:0] hdr_cnt;
    logic                      failed;

    t_gz_byte    pending_bytes[$];
    t_gz_result  expected_results[$];
    t_gz_result  seen;
    t_gz_result  want;
    int unsigned bytes_queued;
    int unsigned phase_goal;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned quiet;
    int unsigned fails;
    logic        hold_req;
    logic        in_took;

    function automatic void clear_parser();
        part    = HDR_FIXED;
        pos     = '0;
        flags   = '0;
        xrem    = '0;
        hdr_cnt = '0;
        failed  = 1'b0;
    endfunction

    // first optional field at or after stage (extra, name, comment, crc) that flags call for
    function automatic t_hdr_part next_field(int stage);
        pos = '0;
        if (stage <= 0 && (flags & ghs_pkg::FLAG_EXTRA) != 0) return HDR_XLEN;
        if (stage <= 1 && (flags & ghs_pkg::FLAG_NAME) != 0) return HDR_NAME;
        if (stage <= 2 && (flags & ghs_pkg::FLAG_COMMENT) != 0) return HDR_COMMENT;
        if (stage <= 3 && (flags & ghs_pkg::FLAG_HCRC) != 0) return HDR_HCRC;
        return BODY;
    endfunction

    function automatic t_gz_result parse_byte(t_gz_byte b);
        t_gz_result r;
        logic       bad;
        bad       = 1'b0;
        r.kind    = ghs_pkg::KIND_HEADER;
        r.payload = '0;
        r.eos     = b.last;
        if (b.start) clear_parser();
        if (failed) begin
            r.kind = ghs_pkg::KIND_DROP;
        end else if (part == BODY) begin
            r.kind    = ghs_pkg::KIND_PAYLOAD;
            r.payload = b.data;
        end else begin
            if (hdr_cnt != ghs_pkg::LEN_MAX) hdr_cnt++;
            case (part)
                HDR_FIXED: begin
                    case (pos)
                        4'd0: bad = (b.data != ghs_pkg::ID1_BYTE);
                        4'd1: bad = (b.data != ghs_pkg::ID2_BYTE);
                        4'd2: bad = (b.data != ghs_pkg::METHOD_DEFLATE);
                        4'd3: begin
                            flags = b.data;
                            bad   = |(b.data & ghs_pkg::FLAG_RESERVED);
                        end
                        default: ;
                    endcase
                    if (!bad && pos == ghs_pkg::FIXED_LAST) part = next_field(0);
                    else pos++;
                end
                HDR_XLEN: begin
                    if (pos == 4'd0) begin
                        xrem = {8'h00, b.data};
                        pos  = 4'd1;
                    end else begin
                        xrem = {b.data, xrem[7:0]};
                        pos  = 4'd0;
                        if (xrem == 16'd0) part = next_field(1);
                        else part = HDR_XDATA;
                    end
                end
                HDR_XDATA: begin
                    xrem--;
                    if (xrem == 16'd0) part = next_field(1);
                end
                HDR_NAME: begin
                    if (b.data == 8'h00) part = next_field(2);
                end
                HDR_COMMENT: begin
                    if (b.data == 8'h00) part = next_field(3);
                end
                HDR_HCRC: begin
                    if (pos == 4'd0) pos = 4'd1;
                    else part = next_field(4);
                end
                default: ;
            endcase
            if (bad) begin
                r.kind = ghs_pkg::KIND_BAD;
                failed = 1'b1;
            end else if (b.last) begin
                r.kind = ghs_pkg::KIND_TRUNC;
                failed = 1'b1;
            end
        end
        r.hlen = hdr_cnt;
        return r;
    endfunction

    task automatic queue_byte(logic [7:0] d, logic s, logic l);
        t_gz_byte b;
        b.data  = d;
        b.start = s;
        b.last  = l;
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // one member; bad_at >= 0 flips bits of the byte at that index,
    // cut_at >= 0 stops the member at that byte if it lies inside the member
    task automatic queue_member(logic [7:0] flg, int xlen, int name_n, int cmt_n,
                                int body_n, int bad_at, logic [7:0] bad_mask,
                                int cut_at, logic cut_final);
        logic [7:0] seq[$];
        int         n;
        logic       closes;
        seq = '{ghs_pkg::ID1_BYTE, ghs_pkg::ID2_BYTE, ghs_pkg::METHOD_DEFLATE, flg};
        repeat (6) seq.push_back(8'($urandom));
        if ((flg & ghs_pkg::FLAG_EXTRA) != 0) begin
            seq.push_back(8'(xlen));
            seq.push_back(8'(xlen >> 8));
            repeat (xlen) seq.push_back(8'($urandom));
        end
        if ((flg & ghs_pkg::FLAG_NAME) != 0) begin
            repeat (name_n) seq.push_back(8'($urandom_range(255, 1)));
            seq.push_back(8'h00);
        end
        if ((flg & ghs_pkg::FLAG_COMMENT) != 0) begin
            repeat (cmt_n) seq.push_back(8'($urandom_range(255, 1)));
            seq.push_back(8'h00);
        end
        if ((flg & ghs_pkg::FLAG_HCRC) != 0) repeat (2) seq.push_back(8'($urandom));
        repeat (body_n) seq.push_back(8'($urandom));
        if (bad_at >= 0) seq[bad_at] = seq[bad_at] ^ bad_mask;
        if (cut_at >= 0 && cut_at < seq.size()) begin
            n      = cut_at + 1;
            closes = cut_final;
        end else begin
            n      = seq.size();
            closes = 1'b1;
        end
        for (int i = 0; i < n; i++)
            queue_byte(seq[i], i == 0, (i == n - 1) && closes);
    endtask

    task automatic queue_random_member();
        logic [7:0] flg;
        int         xlen;
        int         bad_at;
        int         cut_at;
        int         body_n;
        if ($urandom_range(14, 0) == 0)
            repeat ($urandom_range(4, 1))
                queue_byte(8'($urandom), $urandom_range(3, 0) == 0, $urandom_range(3, 0) == 0);
        flg = 8'($urandom_range(31, 0));
        if ($urandom_range(7, 0) == 0) flg = flg | 8'h1e;
        if ($urandom_range(11, 0) == 0) flg = flg | (8'($urandom_range(7, 1)) << 5);
        case ($urandom_range(19, 0))
            0, 1, 2: xlen = 0;
            3:       xlen = $urandom_range(300, 256);
            default: xlen = $urandom_range(6, 1);
        endcase
        bad_at = ($urandom_range(11, 0) == 0) ? $urandom_range(2, 0) : -1;
        cut_at = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 0) : -1;
        body_n = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(12, 1);
        queue_member(flg, xlen, $urandom_range(5, 0), $urandom_range(5, 0), body_n,
                     bad_at, 8'($urandom_range(255, 1)), cut_at, $urandom_range(1, 0));
        if ($urandom_range(9, 0) == 0)
            repeat ($urandom_range(3, 1))
                queue_byte(8'($urandom), 1'b0, $urandom_range(1, 0));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // item driver
    always @(negedge i_clk) begin
        if (!(in_ch.valid && !in_took)) begin
            if (i_rst_n && pending_bytes.size() != 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                in_ch.valid        <= 1'b1;
                in_ch.data_byte    <= pending_bytes[0].data;
                in_ch.stream_start <= pending_bytes[0].start;
                in_ch.final_byte   <= pending_bytes[0].last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // monitor: predict on intake, check on output
    always @(posedge i_clk) begin
        in_took = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                seen.kind    = out_ch.kind;
                seen.payload = out_ch.payload_byte;
                seen.hlen    = out_ch.header_length;
                seen.eos     = out_ch.end_of_stream;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d byte=%02h len=%0d eos=%0b",
                             $time, seen.kind, seen.payload, seen.hlen, seen.eos);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        $display({"%0t: expected kind=%0d byte=%02h len=%0d eos=%0b,",
                                  " actual kind=%0d byte=%02h len=%0d eos=%0b"},
                                 $time, want.kind, want.payload, want.hlen, want.eos,
                                 seen.kind, seen.payload, seen.hlen, seen.eos);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(parse_byte(pending_bytes.pop_front()));
                in_took = 1'b1;
            end
            quiet = (in_took || (out_ch.valid && out_ch.ready)) ? 0 : quiet + 1;
        end
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = 8'h00;
        in_ch.stream_start = 1'b0;
        in_ch.final_byte   = 1'b0;
        out_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        hold_req           = 1'b0;
        hold_left          = 0;
        in_took            = 1'b0;
        quiet              = 0;
        fails              = 0;
        bytes_queued       = 0;
        send_idle_pct      = 8;
        recv_idle_pct      = 79;
        clear_parser();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bad ID1, then a dropped byte
        queue_member(8'h00, 0, 0, 0, 0, 0, 8'h1f, 0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b1);
        // bad ID2, bad method, reserved flag bits
        queue_member(8'h00, 0, 0, 0, 0, 1, 8'h80, 1, 1'b0);
        queue_member(8'h00, 0, 0, 0, 0, 2, 8'h07, 2, 1'b0);
        queue_member(8'hff, 0, 0, 0, 0, -1, 8'h00, 3, 1'b0);
        // stream ends on the last fixed-header byte, then bytes after the end
        queue_member(8'h00, 0, 0, 0, 0, -1, 8'h00, 9, 1'b1);
        queue_byte(8'ha5, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_goal = bytes_queued + RANDOM_BYTES / 3;
            while (bytes_queued < phase_goal) queue_random_member();
            if (p == 2) hold_req = 1'b1;
            while (pending_bytes.size() != 0 || expected_results.size() != 0)
                @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        if (fails == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
